// ----- hw/rtl/i2ctcp_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants shared by the I2C target command parser.
// No dependencies; used by i2ctcp_parser and i2c_target_command_parser.

package i2ctcp_pkg;

	// Bus event kinds as delivered by the I2C target front end.
	typedef enum logic [1:0] {
		EV_ADDR_MATCH = 2'd0,
		EV_READ       = 2'd1,
		EV_WRITE      = 2'd2,
		EV_STOP       = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		PS_IDLE       = 2'd0,
		PS_LED_FIRST  = 2'd1,
		PS_LED_SECOND = 2'd2,
		PS_ADDR       = 2'd3
	} parse_state_t;

	localparam logic [1:0] ACK_NONE = 2'd0;
	localparam logic [1:0] ACK_YES  = 2'd1;
	localparam logic [1:0] ACK_NO   = 2'd2;

	// Command codes carried in the high nibble of a command byte.
	localparam logic [3:0] OP_LEDS    = 4'b0101;
	localparam logic [3:0] OP_ENCODER = 4'b1011;
	localparam logic [3:0] OP_ID      = 4'b1100;

	localparam logic [7:0] ID_LIMIT = 8'h7F;

	typedef struct packed {
		event_t     cmd;
		logic [7:0] data_byte;
	} bus_event_t;

	// Declared from the top bit down so the packed struct is the output tdata word.
	typedef struct packed {
		logic       busy_res;
		logic [6:0] new_id;
		logic       id_valid;
		logic [3:0] encoder_step;
		logic       encoder_valid;
		logic [5:0] led_blue;
		logic [5:0] led_green;
		logic [5:0] led_red;
		logic [1:0] led_button;
		logic       led_valid;
		logic [2:0] sensor_index;
		logic [1:0] ack_code;
	} result_t;

endpackage

// ----- hw/rtl/i2ctcp_parser.sv -----
`timescale 1ns / 1ps
// Parse state and per-event decode of the I2C target command layer.
// Depends on i2ctcp_pkg. State advances on every enabled event.

module i2ctcp_parser #(
	parameter int SENSOR_BYTES = 6,
	parameter int BUTTONS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  i2ctcp_pkg::bus_event_t ev,
	output i2ctcp_pkg::result_t    res
);

	localparam int PTR_W = (SENSOR_BYTES > 1) ? $clog2(SENSOR_BYTES) : 1;
	localparam int LIST_N = (BUTTONS < 4) ? BUTTONS : 4;
	localparam int IDX_W = (LIST_N > 1) ? $clog2(LIST_N) : 1;

	i2ctcp_pkg::parse_state_t state_q, state_d;
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic [2:0]       count_q, count_d;
	logic [2:0]       cursor_q, cursor_d;
	logic             busy_q, busy_d;
	logic [7:0]       first_q;
	logic             first_we;
	logic [1:0]       list_q [LIST_N];
	logic [1:0]       list_new [LIST_N];
	logic             list_we;

	logic [3:0] op;
	logic [3:0] low;
	logic [2:0] cnt;
	logic [8:0] ptr_ext;
	logic [1:0] list_sel;

	assign op       = ev.data_byte[7:4];
	assign low      = ev.data_byte[3:0];
	assign ptr_ext  = 9'(ptr_q);
	assign list_sel = list_q[cursor_q[IDX_W-1:0]];

	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		count_d  = count_q;
		cursor_d = cursor_q;
		busy_d   = busy_q;
		first_we = 1'b0;
		list_we  = 1'b0;
		res      = '0;
		cnt      = 3'd0;
		for (int j = 0; j < LIST_N; j++) begin
			list_new[j] = list_q[j];
		end

		case (ev.cmd)
			i2ctcp_pkg::EV_ADDR_MATCH: begin
				res.ack_code = i2ctcp_pkg::ACK_YES;
				ptr_d    = '0;
				busy_d   = 1'b1;
				state_d  = i2ctcp_pkg::PS_IDLE;
				count_d  = 3'd0;
				cursor_d = 3'd0;
			end
			i2ctcp_pkg::EV_READ: begin
				res.sensor_index = ptr_ext[2:0];
				if (ptr_q == PTR_W'(SENSOR_BYTES - 1)) begin
					ptr_d = '0;
				end else begin
					ptr_d = ptr_q + PTR_W'(1);
				end
				state_d  = i2ctcp_pkg::PS_IDLE;
				count_d  = 3'd0;
				cursor_d = 3'd0;
			end
			i2ctcp_pkg::EV_WRITE: begin
				res.ack_code = i2ctcp_pkg::ACK_YES;
				case (state_q)
					i2ctcp_pkg::PS_IDLE: begin
						if (op == i2ctcp_pkg::OP_ID) begin
							state_d = i2ctcp_pkg::PS_ADDR;
						end else if (op == i2ctcp_pkg::OP_ENCODER) begin
							res.encoder_valid = 1'b1;
							res.encoder_step  = low;
							count_d  = 3'd0;
							cursor_d = 3'd0;
						end else if (op == i2ctcp_pkg::OP_LEDS) begin
							// Mask bits become button numbers in ascending order,
							// keeping only as many as the list can hold.
							for (int i = 0; i < 4; i++) begin
								if (low[i] && ({1'b0, cnt} < 4'(LIST_N))) begin
									list_new[cnt[IDX_W-1:0]] = 2'(i);
									cnt = cnt + 3'd1;
								end
							end
							list_we  = 1'b1;
							count_d  = cnt;
							cursor_d = 3'd0;
							if (cnt == 3'd0) begin
								res.ack_code = i2ctcp_pkg::ACK_NO;
							end else begin
								state_d = i2ctcp_pkg::PS_LED_FIRST;
							end
						end else begin
							res.ack_code = i2ctcp_pkg::ACK_NO;
							count_d  = 3'd0;
							cursor_d = 3'd0;
						end
					end
					i2ctcp_pkg::PS_LED_FIRST: begin
						first_we = 1'b1;
						state_d  = i2ctcp_pkg::PS_LED_SECOND;
					end
					i2ctcp_pkg::PS_LED_SECOND: begin
						res.led_valid  = 1'b1;
						res.led_button = list_sel;
						res.led_red    = first_q[7:2];
						res.led_green  = {first_q[1:0], ev.data_byte[7:4]};
						res.led_blue   = {ev.data_byte[3:0], 2'b00};
						if (cursor_q + 3'd1 >= count_q) begin
							state_d  = i2ctcp_pkg::PS_IDLE;
							count_d  = 3'd0;
							cursor_d = 3'd0;
						end else begin
							state_d  = i2ctcp_pkg::PS_LED_FIRST;
							cursor_d = cursor_q + 3'd1;
						end
					end
					default: begin
						if (ev.data_byte < i2ctcp_pkg::ID_LIMIT) begin
							res.id_valid = 1'b1;
							res.new_id   = ev.data_byte[6:0];
						end
						state_d  = i2ctcp_pkg::PS_IDLE;
						count_d  = 3'd0;
						cursor_d = 3'd0;
					end
				endcase
			end
			default: begin
				busy_d = 1'b0;
			end
		endcase

		res.busy_res = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= i2ctcp_pkg::PS_IDLE;
			ptr_q    <= '0;
			count_q  <= 3'd0;
			cursor_q <= 3'd0;
			busy_q   <= 1'b0;
		end else if (en) begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			busy_q   <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && first_we) begin
			first_q <= ev.data_byte;
		end
		if (en && list_we) begin
			for (int j = 0; j < LIST_N; j++) begin
				list_q[j] <= list_new[j];
			end
		end
	end

endmodule

// ----- hw/rtl/i2c_target_command_parser.sv -----
`timescale 1ns / 1ps
// Top level of the I2C target command parser: stream ports, input and result registers.
// Depends on i2ctcp_pkg and i2ctcp_parser.

// Each bus event item yields exactly one result item. An event is held in the
// input register, is decoded against the parse state in a single pass, and lands in
// the result register; a new item is taken every cycle while the result side keeps
// up, giving a throughput of one item per clock. The input is held back only while
// a result waits and the input register is full. There is no clearing pass after reset.

module i2c_target_command_parser #(
	parameter int SENSOR_BYTES = 6,
	parameter int BUTTONS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// ack_code[1:0], sensor_index[4:2], led_valid[5], led_button[7:6], led_red[13:8],
	// led_green[19:14], led_blue[25:20], encoder_valid[26], encoder_step[30:27],
	// id_valid[31], new_id[38:32], busy_res[39]
	output logic [39:0] m_tdata
);

	logic                   valid_s1;
	i2ctcp_pkg::bus_event_t ev_s1;
	logic                   out_valid_q;
	i2ctcp_pkg::result_t    out_q;
	i2ctcp_pkg::result_t    res;
	logic                   advance;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	i2ctcp_parser #(
		.SENSOR_BYTES(SENSOR_BYTES),
		.BUTTONS(BUTTONS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.en(valid_s1 && advance),
		.ev(ev_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ev_s1.cmd       <= i2ctcp_pkg::event_t'(s_tuser);
			ev_s1.data_byte <= s_tdata;
		end
		if (valid_s1 && advance) begin
			out_q <= res;
		end
	end

endmodule

// ----- test/tb_i2c_target_command_parser.sv -----
`timescale 1ns / 1ps
// Testbench for i2c_target_command_parser: feeds bus event items with random handshake gaps
// and checks every result item against an in-bench model of the command parser.
// Depends on i2ctcp_pkg and the parser RTL.

module tb_i2c_target_command_parser;

	localparam int SENSOR_BYTES = 6;
	localparam int BUTTONS = 4;
	localparam int RANDOM_ITEMS = 1900;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // data_byte[7:0]
	logic [1:0]  s_tuser;  // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // result_t, ack_code in the lowest bits

	i2c_target_command_parser #(
		.SENSOR_BYTES(SENSOR_BYTES),
		.BUTTONS(BUTTONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Parser model state.
	i2ctcp_pkg::parse_state_t model_state;
	int                       sensor_ptr;
	logic [1:0]               button_list [BUTTONS];
	int                       button_count;
	int                       button_cursor;
	logic [7:0]               first_byte;
	logic                     busy;

	i2ctcp_pkg::bus_event_t bus_events[$];
	i2ctcp_pkg::result_t    predicted_results[$];

	int total_items;
	int items_accepted;
	int error_count;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit holding;
	int reads_seen, led_updates, encoder_setups, id_updates, nacks_seen;

	function automatic void clear_parse();
		model_state = i2ctcp_pkg::PS_IDLE;
		button_count = 0;
		button_cursor = 0;
	endfunction

	function automatic i2ctcp_pkg::result_t decode_bus_event(i2ctcp_pkg::event_t ev,
		logic [7:0] b);
		i2ctcp_pkg::result_t r;
		r = '0;
		case (ev)
		i2ctcp_pkg::EV_ADDR_MATCH: begin
			r.ack_code = i2ctcp_pkg::ACK_YES;
			sensor_ptr = 0;
			busy = 1'b1;
			clear_parse();
		end
		i2ctcp_pkg::EV_READ: begin
			clear_parse();
			r.sensor_index = sensor_ptr[2:0];
			sensor_ptr++;
			if (sensor_ptr >= SENSOR_BYTES)
				sensor_ptr = 0;
		end
		i2ctcp_pkg::EV_WRITE: begin
			r.ack_code = i2ctcp_pkg::ACK_YES;
			case (model_state)
			i2ctcp_pkg::PS_IDLE: begin
				if (b[7:4] == i2ctcp_pkg::OP_ID) begin
					model_state = i2ctcp_pkg::PS_ADDR;
				end else if (b[7:4] == i2ctcp_pkg::OP_ENCODER) begin
					r.encoder_valid = 1'b1;
					r.encoder_step = b[3:0];
					clear_parse();
				end else if (b[7:4] == i2ctcp_pkg::OP_LEDS) begin
					button_count = 0;
					for (int i = 0; i < 4; i++) begin
						if (b[i] && button_count < BUTTONS) begin
							button_list[button_count] = i[1:0];
							button_count++;
						end
					end
					if (button_count > 0) begin
						model_state = i2ctcp_pkg::PS_LED_FIRST;
						button_cursor = 0;
					end else begin
						clear_parse();
						r.ack_code = i2ctcp_pkg::ACK_NO;
					end
				end else begin
					clear_parse();
					r.ack_code = i2ctcp_pkg::ACK_NO;
				end
			end
			i2ctcp_pkg::PS_LED_FIRST: begin
				first_byte = b;
				model_state = i2ctcp_pkg::PS_LED_SECOND;
			end
			i2ctcp_pkg::PS_LED_SECOND: begin
				r.led_valid = 1'b1;
				r.led_button = button_list[button_cursor];
				r.led_red = first_byte[7:2];
				r.led_green = {first_byte[1:0], b[7:4]};
				r.led_blue = {b[3:0], 2'b00};
				button_cursor++;
				if (button_cursor >= button_count)
					clear_parse();
				else
					model_state = i2ctcp_pkg::PS_LED_FIRST;
			end
			default: begin
				if (b < i2ctcp_pkg::ID_LIMIT) begin
					r.id_valid = 1'b1;
					r.new_id = b[6:0];
				end
				clear_parse();
			end
			endcase
		end
		default: begin
			busy = 1'b0;
		end
		endcase
		r.busy_res = busy;
		return r;
	endfunction

	task automatic push_event(i2ctcp_pkg::event_t ev, logic [7:0] b);
		i2ctcp_pkg::bus_event_t e;
		e.cmd = ev;
		e.data_byte = b;
		bus_events.push_back(e);
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// Input side: prediction at acceptance.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predicted_results.push_back(
				decode_bus_event(i2ctcp_pkg::event_t'(s_tuser), s_tdata));
			void'(bus_events.pop_front());
			items_accepted++;
			if (i2ctcp_pkg::event_t'(s_tuser) == i2ctcp_pkg::EV_READ)
				reads_seen++;
			holding = 1'b0;
		end
	end

	// Drive both handshakes at the falling edge. The idle mix changes by thirds of the run.
	always @(negedge clk) begin
		if (arst_n) begin
			if (items_accepted * 3 < total_items) begin
				send_idle_pct = 29;
				recv_idle_pct = 45;
			end else if (items_accepted * 3 < total_items * 2) begin
				send_idle_pct = 45;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (!holding) begin
				if (bus_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= bus_events[0].data_byte;
					s_tuser <= bus_events[0].cmd;
					holding = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result side.
	always @(posedge clk) begin
		i2ctcp_pkg::result_t want;
		i2ctcp_pkg::result_t got;
		if (m_tvalid && m_tready) begin
			if (predicted_results.size() == 0) begin
				$error("result item %h arrived with no prediction waiting", m_tdata);
				error_count++;
			end else begin
				want = predicted_results.pop_front();
				got = m_tdata;
				check_field("ack_code", 8'(want.ack_code), 8'(got.ack_code));
				check_field("sensor_index", 8'(want.sensor_index), 8'(got.sensor_index));
				check_field("led_valid", 8'(want.led_valid), 8'(got.led_valid));
				check_field("led_button", 8'(want.led_button), 8'(got.led_button));
				check_field("led_red", 8'(want.led_red), 8'(got.led_red));
				check_field("led_green", 8'(want.led_green), 8'(got.led_green));
				check_field("led_blue", 8'(want.led_blue), 8'(got.led_blue));
				check_field("encoder_valid", 8'(want.encoder_valid),
					8'(got.encoder_valid));
				check_field("encoder_step", 8'(want.encoder_step), 8'(got.encoder_step));
				check_field("id_valid", 8'(want.id_valid), 8'(got.id_valid));
				check_field("new_id", 8'(want.new_id), 8'(got.new_id));
				check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
				led_updates += want.led_valid;
				encoder_setups += want.encoder_valid;
				id_updates += want.id_valid;
				nacks_seen += (want.ack_code == i2ctcp_pkg::ACK_NO);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				predicted_results.size() + bus_events.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int         kind;
		int         pairs;
		int         cut;
		logic [3:0] mask;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		holding = 1'b0;

		model_state = i2ctcp_pkg::PS_IDLE;
		sensor_ptr = 0;
		button_count = 0;
		button_cursor = 0;
		first_byte = '0;
		busy = 1'b0;
		foreach (button_list[i])
			button_list[i] = '0;

		// Directed part. Traffic before any address match is handled as usual.
		push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_ENCODER, 4'hF});
		push_event(i2ctcp_pkg::EV_READ, 8'hFF);
		push_event(i2ctcp_pkg::EV_ADDR_MATCH, 8'hA5);
		// Six reads walk every sensor index; the next one after them wraps.
		repeat (6) push_event(i2ctcp_pkg::EV_READ, 8'h00);
		// Empty button mask is refused.
		push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_LEDS, 4'h0});
		// Buttons 0 and 3 with all-zero and all-one colours.
		push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_LEDS, 4'b1001});
		push_event(i2ctcp_pkg::EV_WRITE, 8'h00);
		push_event(i2ctcp_pkg::EV_WRITE, 8'h00);
		push_event(i2ctcp_pkg::EV_WRITE, 8'hFF);
		push_event(i2ctcp_pkg::EV_WRITE, 8'hFF);
		// Highest accepted address, then the first refused one.
		push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_ID, 4'h0});
		push_event(i2ctcp_pkg::EV_WRITE, 8'h7E);
		push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_ID, 4'hA});
		push_event(i2ctcp_pkg::EV_WRITE, 8'h7F);
		push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_ENCODER, 4'h0});
		push_event(i2ctcp_pkg::EV_WRITE, 8'h00);
		// A stop inside an LED command keeps the parse; a read throws it away.
		push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_LEDS, 4'hF});
		push_event(i2ctcp_pkg::EV_WRITE, 8'h12);
		push_event(i2ctcp_pkg::EV_STOP, 8'h5A);
		push_event(i2ctcp_pkg::EV_WRITE, 8'h34);
		push_event(i2ctcp_pkg::EV_READ, 8'h00);
		push_event(i2ctcp_pkg::EV_STOP, 8'h00);
		total_items = bus_events.size() + RANDOM_ITEMS;

		// Random part: mostly well-formed commands, some cut short or mixed with noise.
		while (bus_events.size() < total_items) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				push_event(i2ctcp_pkg::EV_ADDR_MATCH, 8'($urandom_range(255)));
			end else if (kind < 16) begin
				repeat ($urandom_range(1, 8))
					push_event(i2ctcp_pkg::EV_READ, 8'($urandom_range(255)));
			end else if (kind < 22) begin
				push_event(i2ctcp_pkg::EV_STOP, 8'($urandom_range(255)));
			end else if (kind < 50) begin
				mask = ($urandom_range(19) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
				push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_LEDS, mask});
				pairs = $countones(mask);
				cut = ($urandom_range(7) == 0) ? $urandom_range(0, 2 * pairs) : -1;
				for (int n = 0; n < 2 * pairs; n++) begin
					if (n == cut)
						push_event(i2ctcp_pkg::event_t'($urandom_range(3)),
							8'($urandom_range(255)));
					push_event(i2ctcp_pkg::EV_WRITE, 8'($urandom_range(255)));
				end
			end else if (kind < 65) begin
				push_event(i2ctcp_pkg::EV_WRITE,
					{i2ctcp_pkg::OP_ENCODER, 4'($urandom_range(15))});
			end else if (kind < 82) begin
				push_event(i2ctcp_pkg::EV_WRITE, {i2ctcp_pkg::OP_ID, 4'($urandom_range(15))});
				if ($urandom_range(9) == 0)
					push_event(i2ctcp_pkg::event_t'($urandom_range(3)),
						8'($urandom_range(255)));
				if ($urandom_range(1) == 0)
					push_event(i2ctcp_pkg::EV_WRITE, 8'($urandom_range(0, 126)));
				else
					push_event(i2ctcp_pkg::EV_WRITE, 8'($urandom_range(127, 255)));
			end else begin
				push_event(i2ctcp_pkg::EV_WRITE, 8'($urandom_range(255)));
			end
		end
		total_items = bus_events.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (bus_events.size() != 0 || predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d bus events in %0d cycles under three idle mixes.",
			items_accepted, cycle_count);
		$display("Checked %0d reads, %0d LED updates, %0d encoder setups, %0d address changes, %0d NACKs.",
			reads_seen, led_updates, encoder_setups, id_updates, nacks_seen);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
